// File: rtl/core/assert_macros.svh
// Assertion helpers; the including module provides i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/aes_pkg.sv
package aes_pkg;

    localparam int ROUND_KEY_WORDS = 60;
    localparam int CFG_ADDR_W      = 6;
    localparam int CFG_DATA_W      = 64;

    localparam logic [2:0] REG_KEY_SIZE = 3'd0;
    localparam logic [2:0] REG_KEY_W0   = 3'd1;
    localparam logic [2:0] REG_KEY_W1   = 3'd2;
    localparam logic [2:0] REG_KEY_W2   = 3'd3;
    localparam logic [2:0] REG_KEY_W3   = 3'd4;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
        8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
        8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
        8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
        8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
        8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
        8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
        8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
        8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
        8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
        8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
        8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
        8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
        8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
        8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
        8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
        8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
        8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
        8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
        8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
        8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
        8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
        8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
        8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
        8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
        8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
        8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
        8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
        8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
        8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
        8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
        8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
    };

    function automatic logic [7:0] f_xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] f_gmul(input logic [7:0] a, input logic [3:0] m);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 4; i++) begin
            if (m[i]) begin
                p = p ^ x;
            end
            x = f_xtime(x);
        end
        return p;
    endfunction

    function automatic logic [31:0] f_mix_col(input logic [31:0] w, input logic inv);
        logic [7:0] a0, a1, a2, a3;
        logic [3:0] m0, m1, m2, m3;
        logic [7:0] c0, c1, c2, c3;
        a0 = w[31:24];
        a1 = w[23:16];
        a2 = w[15:8];
        a3 = w[7:0];
        m0 = inv ? 4'd14 : 4'd2;
        m1 = inv ? 4'd11 : 4'd3;
        m2 = inv ? 4'd13 : 4'd1;
        m3 = inv ? 4'd9  : 4'd1;
        c0 = f_gmul(a0, m0) ^ f_gmul(a1, m1) ^ f_gmul(a2, m2) ^ f_gmul(a3, m3);
        c1 = f_gmul(a0, m3) ^ f_gmul(a1, m0) ^ f_gmul(a2, m1) ^ f_gmul(a3, m2);
        c2 = f_gmul(a0, m2) ^ f_gmul(a1, m3) ^ f_gmul(a2, m0) ^ f_gmul(a3, m1);
        c3 = f_gmul(a0, m1) ^ f_gmul(a1, m2) ^ f_gmul(a2, m3) ^ f_gmul(a3, m0);
        return {c0, c1, c2, c3};
    endfunction

    function automatic logic [31:0] f_sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte (col c, row r) sits at bits [127-8*(4c+r) -: 8]
    function automatic logic [127:0] f_sub_shift(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        logic [7:0] v;
        int src;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
                v = s[127 - 8 * (4 * src + r) -: 8];
                t[127 - 8 * (4 * c + r) -: 8] = inv ? INV_SBOX[v] : SBOX[v];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] f_mix(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            t[127 - 32 * c -: 32] = f_mix_col(s[127 - 32 * c -: 32], inv);
        end
        return t;
    endfunction

endpackage

// File: rtl/core/aes_block_cipher_top.sv
// A taken request gets the initial key addition and then each round in turn;
// the last round's result is registered to the outputs together with o_valid.
// The single round unit takes no new request until the previous one finishes.
// After reset and after every write to the key-size or key-word registers
// the key schedule runs with o_stall high; requests wait.
// Reset: synchronous, active low; key registers clear to zero.
`include "assert_macros.svh"

module aes_block_cipher_top #(
    parameter int ROUND_KEY_WORDS = aes_pkg::ROUND_KEY_WORDS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [aes_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [aes_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [aes_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_mode,
    input  logic [63:0]                    i_block_hi,
    input  logic [63:0]                    i_block_lo,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [63:0]                    o_out_hi,
    output logic [63:0]                    o_out_lo
);

    localparam int ROWS  = ROUND_KEY_WORDS / 4;
    localparam int ROW_W = $clog2(ROWS);
    localparam int IDX_W = $clog2(ROUND_KEY_WORDS);

    // configuration
    logic [1:0]  r_key_size;
    logic [63:0] r_key_word [4];
    logic [2:0]  cfg_idx;
    logic        cfg_we;
    logic        cfg_hit;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_hit = cfg_we && (cfg_idx <= aes_pkg::REG_KEY_W3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_size <= 2'd0;
            for (int k = 0; k < 4; k++) begin
                r_key_word[k] <= 64'd0;
            end
        end else if (cfg_we) begin
            unique case (cfg_idx)
                aes_pkg::REG_KEY_SIZE: r_key_size    <= pwdata[1:0];
                aes_pkg::REG_KEY_W0:   r_key_word[0] <= pwdata;
                aes_pkg::REG_KEY_W1:   r_key_word[1] <= pwdata;
                aes_pkg::REG_KEY_W2:   r_key_word[2] <= pwdata;
                aes_pkg::REG_KEY_W3:   r_key_word[3] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            aes_pkg::REG_KEY_SIZE: prdata = {62'd0, r_key_size};
            aes_pkg::REG_KEY_W0:   prdata = r_key_word[0];
            aes_pkg::REG_KEY_W1:   prdata = r_key_word[1];
            aes_pkg::REG_KEY_W2:   prdata = r_key_word[2];
            aes_pkg::REG_KEY_W3:   prdata = r_key_word[3];
            default:               prdata = '0;
        endcase
    end

    // key geometry
    logic [1:0] sel;
    logic [3:0] nk;
    logic [3:0] last_rnd;
    logic [2:0] nk_m1;

    assign sel        = (r_key_size == 2'd3) ? 2'd2 : r_key_size;
    assign nk         = 4'd4 + {1'b0, sel, 1'b0};
    assign last_rnd   = nk + 4'd6;
    assign nk_m1      = 3'(nk - 4'd1);

    // key schedule
    logic             r_exp_run, n_exp_run;
    logic             r_keys_ready, n_keys_ready;
    logic [IDX_W-1:0] r_i, n_i;
    logic [2:0]       r_kc, n_kc;
    logic [7:0]       r_rcon, n_rcon;
    logic [31:0]      r_win [8];
    logic [63:0]      kw;
    logic [31:0]      t_word;
    logic [31:0]      new_word;
    logic             exp_last;
    logic [ROW_W-1:0] wr_row;
    logic [ROW_W-1:0] wr_row_dec;
    logic [1:0]       wr_lane;
    logic [31:0]      dec_word;

    assign kw      = r_key_word[r_i[2:1]];
    assign wr_row  = ROW_W'(r_i >> 2);
    assign wr_lane = r_i[1:0];
    assign wr_row_dec = ROW_W'(last_rnd) - wr_row;
    assign exp_last   = (r_i == IDX_W'({last_rnd, 2'b11}));

    always_comb begin
        t_word = r_win[0];
        n_rcon = r_rcon;
        if (r_kc == 3'd0) begin
            t_word = aes_pkg::f_sub_word({r_win[0][23:0], r_win[0][31:24]})
                     ^ {r_rcon, 24'd0};
            n_rcon = aes_pkg::f_xtime(r_rcon);
        end else if (nk == 4'd8 && r_kc == 3'd4) begin
            t_word = aes_pkg::f_sub_word(r_win[0]);
        end
        if (r_i < IDX_W'(nk)) begin
            new_word = r_i[0] ? kw[31:0] : kw[63:32];
            n_rcon   = r_rcon;
        end else begin
            new_word = r_win[nk_m1] ^ t_word;
        end
        dec_word = (wr_row == '0 || wr_row == ROW_W'(last_rnd))
                   ? new_word : aes_pkg::f_mix_col(new_word, 1'b1);
    end

    always_comb begin
        n_exp_run    = r_exp_run;
        n_keys_ready = r_keys_ready;
        n_i          = r_i;
        n_kc         = r_kc;
        if (cfg_hit) begin
            n_exp_run    = 1'b1;
            n_keys_ready = 1'b0;
            n_i          = '0;
            n_kc         = 3'd0;
        end else if (r_exp_run) begin
            n_i  = r_i + IDX_W'(1);
            n_kc = (r_kc == nk_m1) ? 3'd0 : r_kc + 3'd1;
            if (exp_last) begin
                n_exp_run    = 1'b0;
                n_keys_ready = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_run    <= 1'b1;
            r_keys_ready <= 1'b0;
            r_i          <= '0;
            r_kc         <= 3'd0;
            r_rcon       <= 8'h01;
        end else begin
            r_exp_run    <= n_exp_run;
            r_keys_ready <= n_keys_ready;
            r_i          <= n_i;
            r_kc         <= n_kc;
            if (cfg_hit) begin
                r_rcon <= 8'h01;
            end else if (r_exp_run) begin
                r_rcon <= n_rcon;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_exp_run && !cfg_hit) begin
            r_win[0] <= new_word;
            for (int k = 1; k < 8; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    // round-key memories, one 128-bit row per round, lane k = column k
    logic [127:0]     r_enc_mem [ROWS];
    logic [127:0]     r_dec_mem [ROWS];
    logic [127:0]     r_enc_rd;
    logic [127:0]     r_dec_rd;
    logic [ROW_W-1:0] rd_row;
    logic             mem_we;

    assign mem_we = r_exp_run && !cfg_hit;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_enc_mem[wr_row][{~wr_lane, 5'd0} +: 32]     <= new_word;
            r_dec_mem[wr_row_dec][{~wr_lane, 5'd0} +: 32] <= dec_word;
        end
        r_enc_rd <= r_enc_mem[rd_row];
        r_dec_rd <= r_dec_mem[rd_row];
    end

    // round engine
    logic             r_busy;
    logic             r_mode;
    logic [ROW_W-1:0] r_rnd;
    logic [127:0]     r_state;
    logic [127:0]     rk;
    logic [127:0]     sub_sh;
    logic             in_acc;
    logic             at_last;
    logic             finish;
    logic             hold;
    logic             r_o_valid;
    logic [127:0]     r_out;

    assign o_stall = !r_keys_ready || r_busy;
    assign in_acc  = i_valid && !o_stall;
    assign at_last = r_busy && (r_rnd == ROW_W'(last_rnd));
    assign finish  = at_last && (!r_o_valid || !i_stall);
    assign hold    = at_last && !finish;
    assign rk      = r_mode ? r_dec_rd : r_enc_rd;
    assign sub_sh  = aes_pkg::f_sub_shift(r_state, r_mode);

    always_comb begin
        if (in_acc) begin
            rd_row = '0;
        end else if (at_last) begin
            rd_row = r_rnd;
        end else begin
            rd_row = r_rnd + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_rnd     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end else if (finish) begin
                r_busy <= 1'b0;
            end else if (r_busy && !hold) begin
                r_rnd <= r_rnd + ROW_W'(1);
            end
            if (finish) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode  <= i_mode;
            r_state <= {i_block_hi, i_block_lo};
        end else if (r_busy && !at_last) begin
            if (r_rnd == '0) begin
                r_state <= r_state ^ rk;
            end else begin
                r_state <= aes_pkg::f_mix(sub_sh, r_mode) ^ rk;
            end
        end
        if (finish) begin
            r_out <= sub_sh ^ rk;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_out_hi = r_out[127:64];
    assign o_out_lo = r_out[63:0];

    `ASSERT_NXT(a_acc_busy, in_acc, r_busy && r_rnd == '0)
    `ASSERT_IMP(a_no_wr_busy, r_exp_run, !r_busy)
    `ASSERT_NXT(a_fin_out, finish, r_o_valid && !r_busy)
    `ASSERT_NXT(a_exp_done, r_exp_run && exp_last && !cfg_hit, r_keys_ready && !r_exp_run)

endmodule
